/* sv/lmb_pkg.sv */
// Shared types and constants for the line minimum bracketer.
// Item layouts, result codes, configuration map and register defaults.
// No dependencies; compiled first.
package lmb_pkg;

	localparam int WORD_W     = 32;
	localparam int FRAC_W     = 16;
	localparam int RECIP_W    = 19;
	localparam int COUNT_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 19;
	localparam int SLOT_COUNT = 3;

	typedef enum logic [1:0] {
		KIND_EVAL  = 2'd0,
		KIND_FOUND = 2'd1,
		KIND_FAIL  = 2'd2
	} kind_t;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_VALUE = 1'b1;

	localparam logic SIDE_LEFT  = 1'b0;
	localparam logic SIDE_RIGHT = 1'b1;

	localparam logic [1:0] DIR_NONE  = 2'd0;
	localparam logic [1:0] DIR_LEFT  = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_GOLDEN_FRACTION   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GOLDEN_RECIPROCAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EVAL_LIMIT        = 2'd2;

	localparam logic [FRAC_W-1:0]  GOLDEN_FRACTION_RST   = 16'd25033;
	localparam logic [RECIP_W-1:0] GOLDEN_RECIPROCAL_RST = 19'd171573;
	localparam logic [COUNT_W-1:0] EVAL_LIMIT_RST        = 16'd100;

	typedef struct packed {
		logic [FRAC_W-1:0]  golden_fraction;
		logic [RECIP_W-1:0] golden_reciprocal;
		logic [COUNT_W-1:0] eval_limit;
	} cfg_t;

	// buffer slot held by each bracket position
	typedef struct packed {
		logic [1:0] center;
		logic [1:0] right;
		logic [1:0] left;
	} slot_map_t;

	localparam slot_map_t SLOT_MAP_RST = '{center: 2'd2, right: 2'd1, left: 2'd0};

	typedef struct packed {
		logic                     cmd;
		logic signed [WORD_W-1:0] point_a;
		logic signed [WORD_W-1:0] point_b;
		logic signed [WORD_W-1:0] value_a;
		logic signed [WORD_W-1:0] value_b;
		logic signed [WORD_W-1:0] value_new;
	} in_item_t;

	typedef struct packed {
		kind_t                    kind;
		logic signed [WORD_W-1:0] query_point;
		logic [1:0]               slot;
		logic signed [WORD_W-1:0] lower_point;
		logic signed [WORD_W-1:0] middle_point;
		logic signed [WORD_W-1:0] upper_point;
		logic signed [WORD_W-1:0] lower_value;
		logic signed [WORD_W-1:0] middle_value;
		logic signed [WORD_W-1:0] upper_value;
	} out_item_t;

endpackage

/* sv/lmb_if.sv */
// Valid/ready channels for input items and result items.
// Payload types come from lmb_pkg.
interface lmb_item_if import lmb_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface lmb_result_if import lmb_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* sv/lmb_cfg_regs.sv */
// Configuration registers: golden fraction, its reciprocal, evaluation limit.
// Uses lmb_pkg for the register map and reset values.
module lmb_cfg_regs import lmb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.golden_fraction   <= GOLDEN_FRACTION_RST;
			cfg_q.golden_reciprocal <= GOLDEN_RECIPROCAL_RST;
			cfg_q.eval_limit        <= EVAL_LIMIT_RST;
		end else if (wr_en) begin
			unique case (index)
				CFG_GOLDEN_FRACTION:   cfg_q.golden_fraction   <= data[FRAC_W-1:0];
				CFG_GOLDEN_RECIPROCAL: cfg_q.golden_reciprocal <= data[RECIP_W-1:0];
				CFG_EVAL_LIMIT:        cfg_q.eval_limit        <= data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/lmb_step_point.sv */
// Scaled step: base +/- floor((x - y) * coef / 2^16), saturated to 32 bits.
// Combinational; one 33x20 signed multiply. Uses lmb_pkg widths.
module lmb_step_point import lmb_pkg::*; (
	input  logic signed [WORD_W-1:0] base,
	input  logic signed [WORD_W-1:0] x,
	input  logic signed [WORD_W-1:0] y,
	input  logic [RECIP_W-1:0]       coef,
	input  logic                     minus,
	output logic signed [WORD_W-1:0] point
);

	localparam int DIFF_W = WORD_W + 1;
	localparam int PROD_W = DIFF_W + RECIP_W + 1;
	localparam int SUM_W  = PROD_W - FRAC_W + 1;

	logic signed [DIFF_W-1:0]  diff;
	logic signed [RECIP_W:0]   coef_s;
	logic signed [PROD_W-1:0]  prod;
	logic signed [SUM_W-1:0]   base_x;
	logic signed [SUM_W-1:0]   step_x;
	logic signed [SUM_W-1:0]   sum;

	localparam logic signed [SUM_W-1:0] MAX_X = SUM_W'(2147483647);
	localparam logic signed [SUM_W-1:0] MIN_X = -SUM_W'(64'sd2147483648);

	always_comb begin
		diff   = DIFF_W'(x) - DIFF_W'(y);
		coef_s = $signed({1'b0, coef});
		prod   = diff * coef_s;
		// dropping the low bits of a two's complement product floors it
		base_x = SUM_W'(base);
		step_x = SUM_W'($signed(prod[PROD_W-1:FRAC_W]));
		sum    = minus ? (base_x - step_x) : (base_x + step_x);
		if (sum > MAX_X)
			point = MAX_X[WORD_W-1:0];
		else if (sum < MIN_X)
			point = MIN_X[WORD_W-1:0];
		else
			point = sum[WORD_W-1:0];
	end

endmodule

/* sv/lmb_search_ctrl.sv */
// Bracketing state and single-pass decision logic for one item.
// Holds points, values, slot map and counters; uses lmb_step_point, lmb_pkg.
module lmb_search_ctrl import lmb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output logic      has_result,
	output out_item_t res
);

	typedef enum logic [2:0] {
		MV_START_LEFT,
		MV_START_RIGHT,
		MV_SHIFT_RIGHT,
		MV_EXT_RIGHT_G,
		MV_SHIFT_LEFT,
		MV_EXT_LEFT_G,
		MV_EQ_LEFT,
		MV_EQ_RIGHT
	} move_t;

	logic signed [WORD_W-1:0] left_point_q, center_point_q, right_point_q;
	logic signed [WORD_W-1:0] left_value_q, center_value_q, right_value_q;
	logic [1:0]               last_dir_q;
	logic [COUNT_W-1:0]       eval_count_q;
	logic                     side_q;
	slot_map_t                slot_map_q;

	logic signed [WORD_W-1:0] lp_n, cp_n, rp_n, lv_n, cv_n, rv_n;
	logic [1:0]               dir_n;
	logic [COUNT_W-1:0]       count_n;
	logic                     side_n;
	slot_map_t                map_n;

	logic signed [WORD_W-1:0] lv, cv, rv;
	logic                     is_start, found, fail;
	logic [COUNT_W:0]         next_count;
	move_t                    move;

	logic signed [WORD_W-1:0] st_base, st_x, st_y, new_point;
	logic [RECIP_W-1:0]       st_coef;
	logic                     st_minus;

	always_comb begin
		is_start   = item.cmd == CMD_START;
		has_result = is_start || (eval_count_q != '0);
		lv         = (side_q == SIDE_LEFT)  ? item.value_new : left_value_q;
		rv         = (side_q == SIDE_RIGHT) ? item.value_new : right_value_q;
		cv         = center_value_q;
		found      = !is_start && (cv < lv) && (cv < rv);
		next_count = {1'b0, eval_count_q} + 1'b1;
		fail       = !is_start && !found && (next_count >= {1'b0, cfg.eval_limit});

		if (is_start)
			move = (item.value_b >= item.value_a) ? MV_START_LEFT : MV_START_RIGHT;
		else if (cv < lv)
			move = (cv > rv) ? MV_SHIFT_RIGHT : MV_EXT_RIGHT_G;
		else if (cv > lv)
			move = MV_SHIFT_LEFT;
		else if (cv < rv)
			move = MV_EXT_LEFT_G;
		else if (cv > rv)
			move = MV_SHIFT_RIGHT;
		else
			move = (last_dir_q == DIR_RIGHT) ? MV_EQ_LEFT : MV_EQ_RIGHT;
	end

	always_comb begin
		st_x     = right_point_q;
		st_y     = left_point_q;
		st_base  = right_point_q;
		st_coef  = cfg.golden_reciprocal;
		st_minus = 1'b0;
		case (move)
			MV_START_LEFT: begin
				st_base = item.point_b; st_x = item.point_b; st_y = item.point_a;
				st_minus = 1'b1;
			end
			MV_START_RIGHT: begin
				st_base = item.point_a; st_x = item.point_b; st_y = item.point_a;
			end
			MV_SHIFT_RIGHT: begin
				st_base = center_point_q; st_x = right_point_q; st_y = center_point_q;
			end
			MV_EXT_RIGHT_G: begin
				st_coef = RECIP_W'(cfg.golden_fraction);
			end
			MV_SHIFT_LEFT: begin
				st_base = center_point_q; st_x = center_point_q; st_y = left_point_q;
				st_minus = 1'b1;
			end
			MV_EXT_LEFT_G: begin
				st_base = left_point_q; st_coef = RECIP_W'(cfg.golden_fraction);
				st_minus = 1'b1;
			end
			MV_EQ_LEFT: begin
				st_base = left_point_q; st_minus = 1'b1;
			end
			default: ;
		endcase
	end

	lmb_step_point u_step (
		.base  (st_base),
		.x     (st_x),
		.y     (st_y),
		.coef  (st_coef),
		.minus (st_minus),
		.point (new_point)
	);

	always_comb begin
		lp_n    = left_point_q;
		cp_n    = center_point_q;
		rp_n    = right_point_q;
		lv_n    = lv;
		cv_n    = cv;
		rv_n    = rv;
		dir_n   = last_dir_q;
		count_n = next_count[COUNT_W-1:0];
		side_n  = side_q;
		map_n   = slot_map_q;

		if (is_start) begin
			lp_n    = item.point_a;
			rp_n    = item.point_b;
			lv_n    = item.value_a;
			rv_n    = item.value_b;
			dir_n   = DIR_NONE;
			count_n = COUNT_W'(1);
		end else if (found || fail) begin
			count_n = '0;
		end

		if (!found && !fail) begin
			case (move)
				MV_START_LEFT: begin
					cp_n = item.point_a; cv_n = item.value_a; lp_n = new_point;
					map_n = '{center: SLOT_MAP_RST.left, right: SLOT_MAP_RST.right,
						left: SLOT_MAP_RST.center};
					side_n = SIDE_LEFT;
				end
				MV_START_RIGHT: begin
					cp_n = item.point_b; cv_n = item.value_b; rp_n = new_point;
					map_n = '{center: SLOT_MAP_RST.right, right: SLOT_MAP_RST.center,
						left: SLOT_MAP_RST.left};
					side_n = SIDE_RIGHT;
				end
				MV_SHIFT_RIGHT: begin
					lp_n = center_point_q; lv_n = cv;
					cp_n = right_point_q;  cv_n = rv;
					rp_n = new_point;
					map_n = '{center: slot_map_q.right, right: slot_map_q.left,
						left: slot_map_q.center};
					side_n = SIDE_RIGHT;
				end
				MV_EXT_RIGHT_G: begin
					rp_n = new_point; dir_n = DIR_LEFT; side_n = SIDE_RIGHT;
				end
				MV_SHIFT_LEFT: begin
					rp_n = center_point_q; rv_n = cv;
					cp_n = left_point_q;   cv_n = lv;
					lp_n = new_point;
					map_n = '{center: slot_map_q.left, right: slot_map_q.center,
						left: slot_map_q.right};
					side_n = SIDE_LEFT;
				end
				MV_EXT_LEFT_G: begin
					lp_n = new_point; dir_n = DIR_RIGHT; side_n = SIDE_LEFT;
				end
				MV_EQ_LEFT: begin
					lp_n = new_point; dir_n = DIR_LEFT; side_n = SIDE_LEFT;
				end
				MV_EQ_RIGHT: begin
					rp_n = new_point; dir_n = DIR_RIGHT; side_n = SIDE_RIGHT;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		res = '0;
		if (found) begin
			res.kind         = KIND_FOUND;
			res.slot         = slot_map_q.center;
			res.lower_point  = left_point_q;
			res.middle_point = center_point_q;
			res.upper_point  = right_point_q;
			res.lower_value  = lv;
			res.middle_value = cv;
			res.upper_value  = rv;
		end else if (fail) begin
			res.kind = KIND_FAIL;
		end else begin
			res.kind        = KIND_EVAL;
			res.query_point = new_point;
			res.slot        = (side_n == SIDE_LEFT) ? map_n.left : map_n.right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_dir_q   <= DIR_NONE;
			eval_count_q <= '0;
			side_q       <= SIDE_LEFT;
			slot_map_q   <= SLOT_MAP_RST;
		end else if (fire && has_result) begin
			last_dir_q   <= dir_n;
			eval_count_q <= count_n;
			side_q       <= side_n;
			slot_map_q   <= map_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_result) begin
			left_point_q   <= lp_n;
			center_point_q <= cp_n;
			right_point_q  <= rp_n;
			left_value_q   <= lv_n;
			center_value_q <= cv_n;
			right_value_q  <= rv_n;
		end
	end

	a_slot_map_perm: assert property (@(posedge clk) disable iff (!arst_n)
		slot_map_q.left < SLOT_COUNT && slot_map_q.right < SLOT_COUNT &&
		slot_map_q.center < SLOT_COUNT && slot_map_q.left != slot_map_q.right &&
		slot_map_q.left != slot_map_q.center && slot_map_q.right != slot_map_q.center)
		else $error("slot map is not a permutation");

	a_end_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && has_result && res.kind != KIND_EVAL |=> eval_count_q == '0)
		else $error("search still active after bracket or failure");

	a_request_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fire && has_result && res.kind == KIND_EVAL |=> eval_count_q != '0)
		else $error("evaluation request issued but search idle");

endmodule

/* sv/line_minimum_bracketer.sv */
// Line minimum bracketer: golden-ratio expansion until a minimum is enclosed.
// Result items are registered from the input register as their items advance.
// One item per cycle unless a held result stalls; idle value items yield none.
// The input register and result register decouple both sides under stalls.
// Reset (async, active low) clears control state and restores register defaults.
module line_minimum_bracketer import lmb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lmb_item_if.sink              item,
	lmb_result_if.source          result
);

	cfg_t      cfg;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      has_result;
	logic      advance;
	out_item_t res;
	logic      out_valid_q;
	out_item_t out_q;

	lmb_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	lmb_search_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.item       (item_s1),
		.cfg        (cfg),
		.has_result (has_result),
		.res        (res)
	);

	// an item that makes no result leaves without waiting on the output side
	assign advance    = valid_s1 && (!has_result || !out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (item.ready)
				valid_s1 <= item.valid;
			if (advance && has_result)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid)
			item_s1 <= item.data;
		if (advance && has_result)
			out_q <= res;
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("pending item lost or overwritten");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.data))
		else $error("stalled result item dropped or changed");

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item.ready)
		else $error("input register empty but item not accepted");

endmodule

/* test/lmb_bracket_checker.sv */
`timescale 1ns / 100ps
// Watches the register port and both item channels of line_minimum_bracketer,
// predicts each result from its own copy of the search state and compares.
// Depends on lmb_pkg and the channel interfaces in lmb_if.
module lmb_bracket_checker import lmb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lmb_item_if                   item_ch,
	lmb_result_if                 result_ch,
	output int                    mismatches,
	output int                    outstanding,
	output int                    requests_seen,
	output int                    brackets_seen,
	output int                    failures_seen
);

	localparam longint WORD_MAX = 64'sh7FFFFFFF;
	localparam longint WORD_MIN = -64'sh80000000;
	localparam int     REPORT_CAP = 50;

	logic [FRAC_W-1:0]  cfg_frac;
	logic [RECIP_W-1:0] cfg_recip;
	logic [COUNT_W-1:0] cfg_limit;

	// bracket as the block should hold it
	logic signed [WORD_W-1:0] lo_pt, mid_pt, hi_pt;
	logic signed [WORD_W-1:0] lo_val, mid_val, hi_val;
	logic [1:0]               last_dir;
	logic [COUNT_W-1:0]       evals;
	logic                     fill_side;
	slot_map_t                slots;

	out_item_t awaited_results[$];

	task automatic report(input string msg);
		if (mismatches < REPORT_CAP)
			$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// base +/- floor(diff * coef / 2^16), clamped to the word range
	function automatic logic signed [WORD_W-1:0] golden_step(
			input logic signed [WORD_W-1:0] base, input longint diff,
			input logic [RECIP_W-1:0] coef, input bit toward_low);
		longint delta, sum;
		delta = (diff * longint'(coef)) >>> 16;
		sum = toward_low ? longint'(base) - delta : longint'(base) + delta;
		if (sum > WORD_MAX)
			sum = WORD_MAX;
		else if (sum < WORD_MIN)
			sum = WORD_MIN;
		return sum[WORD_W-1:0];
	endfunction

	task automatic issue_request(input logic side, input logic signed [WORD_W-1:0] pt);
		out_item_t want;
		fill_side = side;
		if (side == SIDE_LEFT)
			lo_pt = pt;
		else
			hi_pt = pt;
		want = '0;
		want.kind = KIND_EVAL;
		want.query_point = pt;
		want.slot = (side == SIDE_LEFT) ? slots.left : slots.right;
		awaited_results.push_back(want);
	endtask

	// slide the bracket one step to the right and expand past the new center
	task automatic advance_right();
		lo_pt = mid_pt;
		lo_val = mid_val;
		{slots.left, slots.center} = {slots.center, slots.left};
		mid_pt = hi_pt;
		mid_val = hi_val;
		{slots.center, slots.right} = {slots.right, slots.center};
		hi_pt = golden_step(lo_pt, longint'(mid_pt) - longint'(lo_pt), cfg_recip, 1'b0);
	endtask

	task automatic predict_step(input in_item_t it);
		out_item_t          want;
		logic [COUNT_W:0]   next_count;
		longint             span;
		if (it.cmd == CMD_START) begin
			lo_pt = it.point_a;
			hi_pt = it.point_b;
			lo_val = it.value_a;
			hi_val = it.value_b;
			slots = SLOT_MAP_RST;
			last_dir = DIR_NONE;
			evals = COUNT_W'(1);
			if (hi_val >= lo_val) begin
				mid_pt = lo_pt;
				mid_val = lo_val;
				{slots.left, slots.center} = {slots.center, slots.left};
				issue_request(SIDE_LEFT, golden_step(hi_pt,
					longint'(hi_pt) - longint'(mid_pt), cfg_recip, 1'b1));
			end else begin
				mid_pt = hi_pt;
				mid_val = hi_val;
				{slots.center, slots.right} = {slots.right, slots.center};
				issue_request(SIDE_RIGHT, golden_step(lo_pt,
					longint'(mid_pt) - longint'(lo_pt), cfg_recip, 1'b0));
			end
			return;
		end

		// no search running: the item is dropped
		if (evals == 0)
			return;

		if (fill_side == SIDE_LEFT)
			lo_val = it.value_new;
		else
			hi_val = it.value_new;

		if (mid_val < lo_val && mid_val < hi_val) begin
			want = '0;
			want.kind = KIND_FOUND;
			want.slot = slots.center;
			want.lower_point = lo_pt;
			want.middle_point = mid_pt;
			want.upper_point = hi_pt;
			want.lower_value = lo_val;
			want.middle_value = mid_val;
			want.upper_value = hi_val;
			awaited_results.push_back(want);
			evals = 0;
			return;
		end

		next_count = evals + 17'd1;
		if (next_count >= cfg_limit) begin
			want = '0;
			want.kind = KIND_FAIL;
			awaited_results.push_back(want);
			evals = 0;
			return;
		end
		evals = next_count[COUNT_W-1:0];

		span = longint'(hi_pt) - longint'(lo_pt);
		if (mid_val < lo_val) begin
			if (mid_val > hi_val) begin
				advance_right();
				issue_request(SIDE_RIGHT, hi_pt);
			end else begin
				last_dir = DIR_LEFT;
				issue_request(SIDE_RIGHT, golden_step(hi_pt, span, cfg_frac, 1'b0));
			end
		end else if (mid_val > lo_val) begin
			hi_pt = mid_pt;
			hi_val = mid_val;
			{slots.center, slots.right} = {slots.right, slots.center};
			mid_pt = lo_pt;
			mid_val = lo_val;
			{slots.left, slots.center} = {slots.center, slots.left};
			issue_request(SIDE_LEFT, golden_step(hi_pt,
				longint'(hi_pt) - longint'(mid_pt), cfg_recip, 1'b1));
		end else if (mid_val < hi_val) begin
			last_dir = DIR_RIGHT;
			issue_request(SIDE_LEFT, golden_step(lo_pt, span, cfg_frac, 1'b1));
		end else if (mid_val > hi_val) begin
			advance_right();
			issue_request(SIDE_RIGHT, hi_pt);
		end else if (last_dir == DIR_RIGHT) begin
			// flat on all three points: alternate the side we expand
			last_dir = DIR_LEFT;
			issue_request(SIDE_LEFT, golden_step(lo_pt, span, cfg_recip, 1'b1));
		end else begin
			last_dir = DIR_RIGHT;
			issue_request(SIDE_RIGHT, golden_step(hi_pt, span, cfg_recip, 1'b0));
		end
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (awaited_results.size() == 0) begin
			report($sformatf("result item of kind %0d with nothing expected", got.kind));
			return;
		end
		want = awaited_results.pop_front();
		case (want.kind)
			KIND_EVAL:  requests_seen++;
			KIND_FOUND: brackets_seen++;
			default:    failures_seen++;
		endcase
		if (got.kind !== want.kind)
			report($sformatf("kind got %0d want %0d", got.kind, want.kind));
		if (got.query_point !== want.query_point)
			report($sformatf("query_point got %0d want %0d", got.query_point,
				want.query_point));
		if (got.slot !== want.slot)
			report($sformatf("slot got %0d want %0d", got.slot, want.slot));
		if (got.lower_point !== want.lower_point)
			report($sformatf("lower_point got %0d want %0d", got.lower_point,
				want.lower_point));
		if (got.middle_point !== want.middle_point)
			report($sformatf("middle_point got %0d want %0d", got.middle_point,
				want.middle_point));
		if (got.upper_point !== want.upper_point)
			report($sformatf("upper_point got %0d want %0d", got.upper_point,
				want.upper_point));
		if (got.lower_value !== want.lower_value)
			report($sformatf("lower_value got %0d want %0d", got.lower_value,
				want.lower_value));
		if (got.middle_value !== want.middle_value)
			report($sformatf("middle_value got %0d want %0d", got.middle_value,
				want.middle_value));
		if (got.upper_value !== want.upper_value)
			report($sformatf("upper_value got %0d want %0d", got.upper_value,
				want.upper_value));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_frac = GOLDEN_FRACTION_RST;
			cfg_recip = GOLDEN_RECIPROCAL_RST;
			cfg_limit = EVAL_LIMIT_RST;
			lo_pt = '0;
			mid_pt = '0;
			hi_pt = '0;
			lo_val = '0;
			mid_val = '0;
			hi_val = '0;
			last_dir = DIR_NONE;
			evals = '0;
			fill_side = SIDE_LEFT;
			slots = SLOT_MAP_RST;
			awaited_results.delete();
			outstanding = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_GOLDEN_FRACTION:   cfg_frac = cfg_data[FRAC_W-1:0];
					CFG_GOLDEN_RECIPROCAL: cfg_recip = cfg_data[RECIP_W-1:0];
					CFG_EVAL_LIMIT:        cfg_limit = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			// a result always trails its item, so results go first
			if (result_ch.valid && result_ch.ready)
				check_result(result_ch.data);
			if (item_ch.valid && item_ch.ready)
				predict_step(item_ch.data);
			outstanding = awaited_results.size();
		end
	end

endmodule

/* test/line_minimum_bracketer_tb.sv */
`timescale 1ns / 100ps
// Top of the line_minimum_bracketer testbench: clock, reset, register writes,
// directed and random item stimulus with random idling, and the verdict.
// Depends on lmb_pkg, lmb_if, lmb_bracket_checker and the block itself.
module line_minimum_bracketer_tb;
	import lmb_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int PHASE_ITEMS  = 100;
	localparam int PHASE_COUNT  = 8;
	localparam int SETTLE_CYCLES = 8;

	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFFFFFF;
	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;
	localparam logic signed [WORD_W-1:0] ONE      = 32'sh00010000;

	typedef enum int {VALS_WIDE, VALS_NARROW, VALS_FALLING, VALS_VALLEY} value_style_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lmb_item_if   item_ch();
	lmb_result_if result_ch();

	int mismatches, outstanding, requests_seen, brackets_seen, failures_seen;
	int sent_count;
	int settings_count;
	int cycles;
	bit steady;

	line_minimum_bracketer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	lmb_bracket_checker bracket_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.item_ch       (item_ch),
		.result_ch     (result_ch),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.requests_seen (requests_seen),
		.brackets_seen (brackets_seen),
		.failures_seen (failures_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic in_item_t start_item(input logic signed [WORD_W-1:0] pa, pb, va, vb);
		in_item_t it;
		it.cmd = CMD_START;
		it.point_a = pa;
		it.point_b = pb;
		it.value_a = va;
		it.value_b = vb;
		it.value_new = $urandom;
		return it;
	endfunction

	function automatic in_item_t value_item(input logic signed [WORD_W-1:0] v);
		in_item_t it;
		it.cmd = CMD_VALUE;
		it.point_a = $urandom;
		it.point_b = $urandom;
		it.value_a = $urandom;
		it.value_b = $urandom;
		it.value_new = v;
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		int unsigned gap;
		item_ch.valid <= 1'b1;
		item_ch.data <= it;
		do @(posedge clk); while (!item_ch.ready);
		sent_count++;
		gap = steady ? 0 : idle_len();
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [FRAC_W-1:0] frac, input logic [RECIP_W-1:0] recip,
			input logic [COUNT_W-1:0] limit);
		write_reg(CFG_GOLDEN_FRACTION, CFG_DATA_W'(frac));
		write_reg(CFG_GOLDEN_RECIPROCAL, CFG_DATA_W'(recip));
		write_reg(CFG_EVAL_LIMIT, CFG_DATA_W'(limit));
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		settings_count++;
	endtask

	// let every expected result arrive, then give a dropped item time to clear
	task automatic drain();
		item_ch.valid <= 1'b0;
		// wait for a clock edge so the checker has seen the last accepted item
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_search(input value_style_t style, input int unsigned len);
		logic signed [WORD_W-1:0] pa, pb, va, vb, v;
		longint level;
		int unsigned i;
		if ($urandom_range(0, 1)) begin
			pa = $urandom;
			pb = $urandom;
		end else begin
			pa = $urandom_range(0, 8 * ONE) - 4 * ONE;
			pb = $urandom_range(0, 8 * ONE) - 4 * ONE;
		end
		level = $urandom_range(0, 1 << 20);
		case (style)
			VALS_WIDE: begin
				va = $urandom;
				vb = $urandom;
			end
			VALS_NARROW: begin
				va = $urandom_range(0, 6) - 3;
				vb = $urandom_range(0, 6) - 3;
			end
			default: begin
				va = WORD_W'(level + $urandom_range(0, 3));
				vb = WORD_W'(level + $urandom_range(0, 3));
			end
		endcase
		send_item(start_item(pa, pb, va, vb));
		for (i = 0; i < len; i++) begin
			case (style)
				VALS_WIDE:   v = $urandom;
				VALS_NARROW: v = $urandom_range(0, 6) - 3;
				default: begin
					// falling keeps every new point lowest; valley turns upward halfway
					if (style == VALS_FALLING || i < len / 2)
						level -= $urandom_range(1, 1 << 16);
					else
						level += $urandom_range(1, 1 << 18);
					if (level < longint'(WORD_MIN))
						level = WORD_MIN;
					if (level > longint'(WORD_MAX))
						level = WORD_MAX;
					v = level[WORD_W-1:0];
				end
			endcase
			send_item(value_item(v));
		end
	endtask

	// result side: runs of ready broken by random stalls
	initial begin
		result_ch.ready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			int unsigned stall;
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			stall = steady ? 0 : idle_len();
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results still expected", cycles, outstanding);
		$display("line_minimum_bracketer_tb failed");
		$finish;
	end

	initial begin
		int p;
		int unsigned pick;
		int phase_base;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_GOLDEN_FRACTION;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		steady = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(GOLDEN_FRACTION_RST, GOLDEN_RECIPROCAL_RST, EVAL_LIMIT_RST);

		// value before any start: dropped
		send_item(value_item(32'sd7));
		// flat start, both flat expansions, right extend, right slide, right extend, bracket
		send_item(start_item(32'sd0, ONE, 32'sd10, 32'sd10));
		send_item(value_item(32'sd10));
		send_item(value_item(32'sd10));
		send_item(value_item(32'sd20));
		send_item(value_item(32'sd5));
		send_item(value_item(32'sd5));
		send_item(value_item(32'sd100));
		// search is over: dropped
		send_item(value_item(32'sd3));
		// left slide, left extend on equal left, left slide, bracket with extreme values
		send_item(start_item(3 * ONE, 5 * ONE, 32'sd3, 32'sd5));
		send_item(value_item(32'sd1));
		send_item(value_item(32'sd1));
		send_item(value_item(WORD_MIN));
		send_item(value_item(WORD_MAX));
		// extreme points saturate; second start restarts a running search
		send_item(start_item(WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN));
		send_item(start_item(WORD_MAX, WORD_MIN, WORD_MIN, WORD_MIN));
		send_item(value_item(WORD_MIN));
		send_item(value_item(WORD_MAX));
		send_item(value_item(32'sd0));
		drain();

		for (p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: set_config(16'd0, 19'd65536, 16'd1);
				1: set_config(16'hFFFF, 19'h7FFFF, 16'hFFFF);
				2: set_config(GOLDEN_FRACTION_RST, GOLDEN_RECIPROCAL_RST, 16'd2);
				3: set_config(16'hFFFF, 19'd65536, 16'd12);
				4: set_config(GOLDEN_FRACTION_RST, GOLDEN_RECIPROCAL_RST, EVAL_LIMIT_RST);
				default: set_config(FRAC_W'($urandom_range(0, 65535)),
					RECIP_W'($urandom_range(65536, 524287)),
					COUNT_W'($urandom_range(1, 300)));
			endcase
			// each phase sends at least PHASE_ITEMS input items
			phase_base = sent_count;
			while (sent_count - phase_base < PHASE_ITEMS) begin
				steady = ($urandom_range(0, 4) == 0);
				pick = $urandom_range(0, 19);
				if (pick == 0)
					send_item(value_item($urandom));
				else if (pick == 1)
					run_search(VALS_FALLING, $urandom_range(10, 110));
				else if (pick < 7)
					run_search(VALS_NARROW, $urandom_range(1, 10));
				else if (pick < 12)
					run_search(VALS_WIDE, $urandom_range(1, 6));
				else
					run_search(VALS_VALLEY, $urandom_range(2, 14));
			end
			steady = 1'b0;
			drain();
		end

		$display("sent %0d items under %0d register settings, directed edge cases included",
			sent_count, settings_count);
		$display("checked %0d evaluation requests, %0d brackets, %0d limit failures",
			requests_seen, brackets_seen, failures_seen);
		if (mismatches == 0)
			$display("line_minimum_bracketer_tb passed");
		else
			$display("line_minimum_bracketer_tb failed");
		$finish;
	end

endmodule

/* sim.f */
sv/lmb_pkg.sv
sv/lmb_if.sv
sv/lmb_cfg_regs.sv
sv/lmb_step_point.sv
sv/lmb_search_ctrl.sv
sv/line_minimum_bracketer.sv
test/lmb_bracket_checker.sv
test/line_minimum_bracketer_tb.sv
